// File: hdl/bora_pkg.sv
// Package for the banked operand-read arbiter: sizes, field layout and lane types.
// It has no dependencies. Every module of the block imports it.
package bora_pkg;

  // Request geometry.
  localparam int REQ_ROWS       = 4;
  localparam int OPS_PER_ROW    = 3;
  localparam int SLOT_COUNT     = REQ_ROWS * OPS_PER_ROW;
  localparam int SLOT_W         = $clog2(SLOT_COUNT);

  // Banks that are searched, and the fixed bank field of a request.
  localparam int BANK_COUNT     = 4;
  localparam int BANK_W         = 2;
  localparam int MAX_BANKS      = 4;

  // Address width used, and the fixed lane width of the packed address words.
  localparam int ADDR_WIDTH     = 8;
  localparam int ADDR_FIELD_W   = 8;
  localparam int SLOTS_PER_WORD = 6;

  // Fixed port widths.
  localparam int MAX_SLOTS      = 12;
  localparam int SLOT_FIELD_W   = 4;
  localparam int ADDR_WORD_W    = SLOTS_PER_WORD * ADDR_FIELD_W;

  // What one bank lane found in the current word.
  typedef struct packed {
    logic              grant;
    logic [SLOT_W-1:0] slot;
  } lane_grant_t;

endpackage

// File: hdl/bora_lane.sv
// One bank lane: round-robin search over all request slots and the bank's pointer.
// Depends on bora_pkg.
module bora_lane
  import bora_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [BANK_W-1:0]     bank_id,
  input  logic [SLOT_COUNT-1:0] request_valid,
  input  logic [BANK_W-1:0]     slot_bank [SLOT_COUNT],
  input  logic                  advance,
  output lane_grant_t           grant_info
);

  logic [SLOT_W-1:0]     last_slot;
  logic [SLOT_COUNT-1:0] req;
  logic [SLOT_COUNT-1:0] req_upper;

  // Requests aimed at this bank, and those that lie after the pointer.
  always_comb begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      req[s]       = request_valid[s] && (slot_bank[s] == bank_id);
      req_upper[s] = req[s] && (SLOT_W'(s) > last_slot);
    end
  end

  // Lowest request after the pointer wins; otherwise wrap to the lowest request.
  always_comb begin
    logic              hit_upper;
    logic [SLOT_W-1:0] idx_upper;
    logic [SLOT_W-1:0] idx_all;
    hit_upper = 1'b0;
    idx_upper = '0;
    idx_all   = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (req_upper[s]) begin
        hit_upper = 1'b1;
        idx_upper = SLOT_W'(s);
      end
      if (req[s]) begin
        idx_all = SLOT_W'(s);
      end
    end
    grant_info.grant = |req;
    grant_info.slot  = hit_upper ? idx_upper : idx_all;
  end

  // The pointer moves to the granted slot when the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_slot <= '0;
    end else if (advance && grant_info.grant) begin
      last_slot <= grant_info.slot;
    end
  end

endmodule

// File: hdl/bora_merge.sv
// Merging stage: combines the lane grants into the result word and registers it.
// Depends on bora_pkg.
module bora_merge
  import bora_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  lane_grant_t                 grants    [BANK_COUNT],
  input  logic [ADDR_WIDTH-1:0]       slot_addr [SLOT_COUNT],
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [MAX_BANKS-1:0]        grant_valid,
  output logic [MAX_BANKS*SLOT_FIELD_W-1:0] grant_slots,
  output logic [MAX_BANKS*ADDR_FIELD_W-1:0] read_addresses,
  output logic [MAX_SLOTS-1:0]        ready_mask
);

  logic [MAX_BANKS-1:0]              grant_valid_next;
  logic [MAX_BANKS*SLOT_FIELD_W-1:0] grant_slots_next;
  logic [MAX_BANKS*ADDR_FIELD_W-1:0] read_addresses_next;
  logic [MAX_SLOTS-1:0]              ready_mask_next;

  // The output register frees up when it is empty or being drained.
  assign in_ready = !out_valid || out_ready;

  // Pack per-bank fields; banks without a grant report zeros.
  always_comb begin
    grant_valid_next    = '0;
    grant_slots_next    = '0;
    read_addresses_next = '0;
    ready_mask_next     = '0;
    for (int b = 0; b < BANK_COUNT; b++) begin
      if (grants[b].grant) begin
        grant_valid_next[b] = 1'b1;
        grant_slots_next[b*SLOT_FIELD_W +: SLOT_FIELD_W] = SLOT_FIELD_W'(grants[b].slot);
        read_addresses_next[b*ADDR_FIELD_W +: ADDR_FIELD_W] =
          ADDR_FIELD_W'(slot_addr[grants[b].slot]);
        ready_mask_next[grants[b].slot] = 1'b1;
      end
    end
  end

  // Result word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result word payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      grant_valid    <= grant_valid_next;
      grant_slots    <= grant_slots_next;
      read_addresses <= read_addresses_next;
      ready_mask     <= ready_mask_next;
    end
  end

endmodule

// File: hdl/banked_operand_read_arbiter_top.sv
// Top level of the banked operand-read arbiter: slot unpacking, bank lanes, merge.
// Depends on bora_pkg, bora_lane and bora_merge.
//
//   channel | handshake           | word
//   --------+---------------------+----------------------------------------------------
//   input   | in_valid / in_ready | request_valid, request_banks, addresses_low/high
//   output  | out_valid/out_ready | grant_valid, grant_slots, read_addresses, ready_mask
//
// A word is taken each cycle in_ready is high; its result shows in the next cycle.
// The round-robin search of all slots for every bank is combinational logic in each lane.
// Reset clears the bank pointers to slot 0 and empties the output register.
// While a result waits, a new word is still taken if out_ready drains the register.
module banked_operand_read_arbiter_top
  import bora_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [MAX_SLOTS-1:0]              request_valid,
  input  logic [MAX_SLOTS*BANK_W-1:0]       request_banks,
  input  logic [ADDR_WORD_W-1:0]            addresses_low,
  input  logic [ADDR_WORD_W-1:0]            addresses_high,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [MAX_BANKS-1:0]              grant_valid,
  output logic [MAX_BANKS*SLOT_FIELD_W-1:0] grant_slots,
  output logic [MAX_BANKS*ADDR_FIELD_W-1:0] read_addresses,
  output logic [MAX_SLOTS-1:0]              ready_mask
);

  logic                  accept;
  logic [BANK_W-1:0]     slot_bank [SLOT_COUNT];
  logic [ADDR_WIDTH-1:0] slot_addr [SLOT_COUNT];
  lane_grant_t           grants    [BANK_COUNT];

  assign accept = in_valid && in_ready;

  // Unpack the bank and address of every slot.
  for (genvar s = 0; s < SLOT_COUNT; s++) begin : g_slot
    assign slot_bank[s] = request_banks[s*BANK_W +: BANK_W];
    if (s < SLOTS_PER_WORD) begin : g_low
      assign slot_addr[s] = addresses_low[s*ADDR_FIELD_W +: ADDR_WIDTH];
    end else begin : g_high
      assign slot_addr[s] = addresses_high[(s-SLOTS_PER_WORD)*ADDR_FIELD_W +: ADDR_WIDTH];
    end
  end

  // One search lane per bank.
  for (genvar b = 0; b < BANK_COUNT; b++) begin : g_lane
    bora_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .bank_id       (BANK_W'(b)),
      .request_valid (request_valid[SLOT_COUNT-1:0]),
      .slot_bank     (slot_bank),
      .advance       (accept),
      .grant_info    (grants[b])
    );
  end

  // Combine the lane grants into the registered result word.
  bora_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .grants         (grants),
    .slot_addr      (slot_addr),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .grant_valid    (grant_valid),
    .grant_slots    (grant_slots),
    .read_addresses (read_addresses),
    .ready_mask     (ready_mask)
  );

endmodule

// File: hdl/bora_checker.sv
// Port-level checks for the banked operand-read arbiter, bound to the top level.
// Depends on bora_pkg and banked_operand_read_arbiter_top.
module bora_assertions
  import bora_pkg::*;
(
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [MAX_BANKS-1:0]              grant_valid,
  input logic [MAX_BANKS*SLOT_FIELD_W-1:0] grant_slots,
  input logic [MAX_BANKS*ADDR_FIELD_W-1:0] read_addresses,
  input logic [MAX_SLOTS-1:0]              ready_mask
);

  // Each grant marks exactly one distinct slot ready.
  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones(ready_mask) == $countones(grant_valid))
    else $error("ready_mask does not match the number of grants");

  // A granted slot shows up in the ready mask.
  a_slot_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!grant_valid[0] || ready_mask[grant_slots[3:0]])
               && (!grant_valid[1] || ready_mask[grant_slots[7:4]])
               && (!grant_valid[2] || ready_mask[grant_slots[11:8]])
               && (!grant_valid[3] || ready_mask[grant_slots[15:12]]))
    else $error("granted slot missing from ready_mask");

  // A bank without a grant reports zero slot and address.
  a_idle_bank_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (grant_valid[0] || (grant_slots[3:0] == 0 && read_addresses[7:0] == 0))
               && (grant_valid[1] || (grant_slots[7:4] == 0 && read_addresses[15:8] == 0))
               && (grant_valid[2] || (grant_slots[11:8] == 0 && read_addresses[23:16] == 0))
               && (grant_valid[3] || (grant_slots[15:12] == 0 && read_addresses[31:24] == 0)))
    else $error("bank without grant reports nonzero fields");

  // A stalled result word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ready_mask) && $stable(grant_slots)
                                && $stable(read_addresses) && $stable(grant_valid))
    else $error("stalled result word changed");

  // Every word taken at the input shows up as a result word in the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result word");

endmodule

bind banked_operand_read_arbiter_top bora_assertions u_bora_assertions (.*);

// File: verif/bora_checker.sv
`timescale 1ns / 100ps
// Checker for the banked operand-read arbiter: watches both channels, predicts each
// grant word with its own per-bank round-robin pointers and compares it field by field.
// Depends on bora_pkg for the slot, bank and address geometry.
module bora_checker
  import bora_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [MAX_SLOTS-1:0]              request_valid,
  input  logic [MAX_SLOTS*BANK_W-1:0]       request_banks,
  input  logic [ADDR_WORD_W-1:0]            addresses_low,
  input  logic [ADDR_WORD_W-1:0]            addresses_high,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [MAX_BANKS-1:0]              grant_valid,
  input  logic [MAX_BANKS*SLOT_FIELD_W-1:0] grant_slots,
  input  logic [MAX_BANKS*ADDR_FIELD_W-1:0] read_addresses,
  input  logic [MAX_SLOTS-1:0]              ready_mask,
  output int                                fail_count,
  output int                                pending,
  output int                                checked
);

  typedef struct packed {
    logic [MAX_BANKS-1:0]              grant_valid;
    logic [MAX_BANKS*SLOT_FIELD_W-1:0] grant_slots;
    logic [MAX_BANKS*ADDR_FIELD_W-1:0] read_addresses;
    logic [MAX_SLOTS-1:0]              ready_mask;
  } grant_word_t;

  // Last granted slot of every bank, and the grant words still owed by the block.
  logic [SLOT_FIELD_W-1:0] last_slot [MAX_BANKS];
  grant_word_t             grant_queue [$];
  int                      mismatches = 0;
  int                      compared = 0;

  // Runs the round-robin search of every bank for one accepted request word,
  // moves the pointers of the banks that granted, and queues the grant word.
  task automatic arbitrate_banks(input logic [MAX_SLOTS-1:0]        valid,
                                 input logic [MAX_SLOTS*BANK_W-1:0] banks,
                                 input logic [ADDR_WORD_W-1:0]      lo,
                                 input logic [ADDR_WORD_W-1:0]      hi);
    grant_word_t             word;
    int                      first;
    int                      s;
    logic                    found;
    logic [ADDR_FIELD_W-1:0] addr;
    logic [ADDR_FIELD_W-1:0] addr_mask;
    word      = '0;
    addr_mask = ADDR_FIELD_W'((1 << ADDR_WIDTH) - 1);
    for (int b = 0; b < BANK_COUNT; b++) begin
      found = 1'b0;
      first = (int'(last_slot[b]) + 1) % SLOT_COUNT;
      for (int n = 0; n < SLOT_COUNT; n++) begin
        s = (first + n) % SLOT_COUNT;
        if (!found && valid[s] && (int'(banks[BANK_W*s +: BANK_W]) == b)) begin
          found = 1'b1;
          if (s < SLOTS_PER_WORD) begin
            addr = lo[ADDR_FIELD_W*s +: ADDR_FIELD_W];
          end else begin
            addr = hi[ADDR_FIELD_W*(s-SLOTS_PER_WORD) +: ADDR_FIELD_W];
          end
          word.grant_valid[b]                               = 1'b1;
          word.grant_slots[SLOT_FIELD_W*b +: SLOT_FIELD_W]  = SLOT_FIELD_W'(s);
          word.read_addresses[ADDR_FIELD_W*b +: ADDR_FIELD_W] = addr & addr_mask;
          word.ready_mask[s]                                = 1'b1;
          last_slot[b]                                      = SLOT_FIELD_W'(s);
        end
      end
    end
    grant_queue.push_back(word);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Results are checked before the new request word is predicted, since a result
  // taken at this edge always belongs to an earlier word.
  always @(posedge clk) begin
    grant_word_t want;
    if (rst) begin
      for (int b = 0; b < MAX_BANKS; b++) begin
        last_slot[b] = '0;
      end
      grant_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (grant_queue.size() == 0) begin
          $error("grant word with no request word waiting: ready_mask %h", ready_mask);
          mismatches++;
        end else begin
          want = grant_queue.pop_front();
          check_field("grant_valid", 32'(want.grant_valid), 32'(grant_valid));
          check_field("grant_slots", 32'(want.grant_slots), 32'(grant_slots));
          check_field("read_addresses", 32'(want.read_addresses), 32'(read_addresses));
          check_field("ready_mask", 32'(want.ready_mask), 32'(ready_mask));
          compared++;
        end
      end
      if (in_valid && in_ready) begin
        arbitrate_banks(request_valid, request_banks, addresses_low, addresses_high);
      end
    end
    fail_count <= mismatches;
    pending    <= grant_queue.size();
    checked    <= compared;
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the banked operand-read arbiter: clock, reset, request stimulus,
// output stalls and the verdict. Depends on bora_pkg, bora_checker and the block's RTL.
module tb_top;
  import bora_pkg::*;

  localparam int RANDOM_PER_PHASE = 425;
  localparam int HOLD_WORDS       = 40;
  localparam int LONG_HOLD        = 50;
  localparam int DRAIN_CYCLES     = 10;
  localparam int WATCHDOG_LIMIT   = 1000;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [MAX_SLOTS-1:0]              request_valid = '0;
  logic [MAX_SLOTS*BANK_W-1:0]       request_banks = '0;
  logic [ADDR_WORD_W-1:0]            addresses_low = '0;
  logic [ADDR_WORD_W-1:0]            addresses_high = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [MAX_BANKS-1:0]              grant_valid;
  logic [MAX_BANKS*SLOT_FIELD_W-1:0] grant_slots;
  logic [MAX_BANKS*ADDR_FIELD_W-1:0] read_addresses;
  logic [MAX_SLOTS-1:0]              ready_mask;

  int fail_count;
  int pending;
  int checked;

  // Idling percentages of the current phase, and the long output hold request.
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int words_sent = 0;
  int quiet_cycles = 0;

  banked_operand_read_arbiter_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .request_valid  (request_valid),
    .request_banks  (request_banks),
    .addresses_low  (addresses_low),
    .addresses_high (addresses_high),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .grant_valid    (grant_valid),
    .grant_slots    (grant_slots),
    .read_addresses (read_addresses),
    .ready_mask     (ready_mask)
  );

  bora_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .request_valid  (request_valid),
    .request_banks  (request_banks),
    .addresses_low  (addresses_low),
    .addresses_high (addresses_high),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .grant_valid    (grant_valid),
    .grant_slots    (grant_slots),
    .read_addresses (read_addresses),
    .ready_mask     (ready_mask),
    .fail_count     (fail_count),
    .pending        (pending),
    .checked        (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls at the phase's rate, or a long hold when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("** banked_operand_read_arbiter_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request word after a random gap and returns at the edge that takes it.
  // Called right after a rising edge.
  task automatic send_request_word(input logic [MAX_SLOTS-1:0]        valid,
                                   input logic [MAX_SLOTS*BANK_W-1:0] banks,
                                   input logic [ADDR_WORD_W-1:0]      lo,
                                   input logic [ADDR_WORD_W-1:0]      hi);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    request_valid  <= valid;
    request_banks  <= banks;
    addresses_low  <= lo;
    addresses_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [ADDR_WORD_W-1:0] random_addresses();
    return ADDR_WORD_W'({$urandom(), $urandom()});
  endfunction

  // Random request words: mixed traffic, with contention on one bank, full
  // request sets, words with one or two requests and empty words mixed in.
  task automatic send_random_word();
    logic [MAX_SLOTS-1:0]        valid;
    logic [MAX_SLOTS*BANK_W-1:0] banks;
    logic [BANK_W-1:0]           hot_bank;
    int                          mode;
    mode     = $urandom_range(0, 9);
    valid    = MAX_SLOTS'($urandom());
    banks    = (MAX_SLOTS*BANK_W)'($urandom());
    hot_bank = BANK_W'($urandom());
    if (mode == 4 || mode == 5) begin
      valid = '1;
    end else if (mode == 6 || mode == 7) begin
      banks = {MAX_SLOTS{hot_bank}};
    end else if (mode == 8) begin
      valid = '0;
      valid[$urandom_range(0, MAX_SLOTS-1)] = 1'b1;
      valid[$urandom_range(0, MAX_SLOTS-1)] = 1'b1;
    end else if (mode == 9) begin
      valid = '0;
    end
    send_request_word(valid, banks, random_addresses(), random_addresses());
  endtask

  // Holds the sender back until every grant word owed has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    int directed;
    phase_idle  = '{0, 83, 0, 15};
    phase_stall = '{0, 0, 83, 15};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words: empty, rotation on one bank, every bank at once, pointer wrap,
    // a lone request equal to the pointer, and extreme field patterns.
    send_request_word('0, '0, '0, '0);
    repeat (3) begin
      send_request_word('1, '0, 48'h0A0908070605, 48'h100F0E0D0C0B);
    end
    send_request_word('1, 24'hE4E4E4, '1, '1);
    send_request_word('1, 24'hE4E4E4, '0, '0);
    send_request_word('1, 24'hFFFFFF, '1, '1);
    send_request_word('1, 24'hAAAAAA, 48'hAAAAAAAAAAAA, 48'h555555555555);
    send_request_word('1, 24'h555555, 48'h555555555555, 48'hAAAAAAAAAAAA);
    send_request_word(12'h800, 24'h800000, '0, 48'hC30000000000);
    send_request_word(12'h001, 24'h000002, 48'h0000000000FE, '0);
    send_request_word(12'h001, 24'h000002, 48'h000000000001, '0);
    send_request_word(12'hA5A, 24'h1B1B1B, 48'h123456789ABC, 48'hFEDCBA987654);
    send_request_word(12'h5A5, 24'hE41BE4, 48'hFFFFFFFFFFFF, 48'h000000000000);
    send_request_word(12'hFFF, 24'h0F0F0F, 48'h80402010_0804, 48'h0102_04081020);
    directed = words_sent;

    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct <= phase_stall[p];
      if (p == 0) begin
        // Long output hold while words keep coming, so the block fills and stalls.
        hold_seq <= hold_seq + 1;
        repeat (HOLD_WORDS) send_random_word();
      end
      repeat (RANDOM_PER_PHASE - ((p == 0) ? HOLD_WORDS : 0)) send_random_word();
      wait_drained();
    end

    stall_pct <= 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request words (%0d directed) over four idling phases and one long hold.",
             words_sent, directed);
    $display("Compared %0d grant words field by field with %0d mismatches.",
             checked, fail_count);
    if (fail_count == 0) begin
      $display("** banked_operand_read_arbiter_top: PASSED **");
    end else begin
      $display("** banked_operand_read_arbiter_top: FAILED **");
    end
    $finish;
  end

endmodule
